>>> rtl/array_list_insert_delete_defines.svh
// Assertion macros used by the array list top level.
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ALID_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ALID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/alid_pkg.sv
// Package with sizes, codes and control types of the array list.
`timescale 1ns / 1ps

package alid_pkg;

    // List geometry.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Field widths of the stream words.
    localparam int CMD_W     = 2;
    localparam int POS_W     = 7;
    localparam int ENTRY_W   = 32;
    localparam int RD_W      = 32;
    localparam int STS_W     = 2;
    localparam int COUNT_FW  = 7;
    localparam int CMP_W     = POS_W + CNT_W;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic rd_shift;
        logic wr_shift;
        logic put;
        logic rd_pos;
        logic commit;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic reject;
        logic more;
    } t_dp_sts;

endpackage

>>> rtl/array_list_insert_delete.sv
// Flow: clear or a rejected command goes from accept through a check to the commit; read
// adds one RAM read, and insert or delete moves k entries through the RAM, each read then written.
// One command at a time; the next word is taken once the result is
// registered, and a finished result may wait in the output register meanwhile.
// Reset (synchronous, active low) empties the list and the output; the entry RAM is
// not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`include "array_list_insert_delete_defines.svh"

module array_list_insert_delete (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: position [6:0], entry_data [38:7], zero pad [39]
    input  logic [alid_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: command [1:0]
    input  logic [alid_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: read_data [31:0], status [33:32], item_count [40:34], is_empty [41],
    // is_full [42], zero pad [47:43]
    output logic [alid_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import alid_pkg::*;

    t_dp_ctl               w_ctl;
    t_dp_sts               w_sts;
    logic [RD_W-1:0]       w_read_data;
    t_status               w_status;
    logic [COUNT_FW-1:0]   w_item_count;
    logic                  w_is_empty;
    logic                  w_is_full;

    alid_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_ctl     (w_ctl),
        .i_sts     (w_sts)
    );

    alid_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cmd        (t_cmd'(s_axis_tuser)),
        .i_position   (s_axis_tdata[POS_W-1:0]),
        .i_entry_data (s_axis_tdata[POS_W+ENTRY_W-1:POS_W]),
        .o_read_data  (w_read_data),
        .o_status     (w_status),
        .o_item_count (w_item_count),
        .o_is_empty   (w_is_empty),
        .o_is_full    (w_is_full)
    );

    // Pack the result word, lowest field first.
    assign m_axis_tdata = OUT_TDATA_W'({w_is_full, w_is_empty, w_item_count,
                                        w_status, w_read_data});

    // A command is worked on alone: after an accept the input side closes.
    `ALID_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a command was in progress")

    // A result is registered only into a free or draining output slot.
    `ALID_ASSERT_IMP(a_commit_slot_free, w_ctl.commit, !m_axis_tvalid || m_axis_tready, "result overwrote a word not yet taken")

    // A full rejection can only be reported while the list is at capacity.
    `ALID_ASSERT_IMP(a_full_status, m_axis_tvalid && w_status == ST_FULL, w_is_full && !w_is_empty, "full status reported with room left")

endmodule

>>> rtl/alid_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module alid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/alid_dpath.sv
// Datapath of the array list: entry memory, count, index and result word.
`timescale 1ns / 1ps

module alid_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  alid_pkg::t_dp_ctl              i_ctl,
    output alid_pkg::t_dp_sts              o_sts,
    input  alid_pkg::t_cmd                 i_cmd,
    input  logic [alid_pkg::POS_W-1:0]     i_position,
    input  logic [alid_pkg::ENTRY_W-1:0]   i_entry_data,
    output logic [alid_pkg::RD_W-1:0]      o_read_data,
    output alid_pkg::t_status              o_status,
    output logic [alid_pkg::COUNT_FW-1:0]  o_item_count,
    output logic                           o_is_empty,
    output logic                           o_is_full
);

    import alid_pkg::*;

    t_cmd                  r_cmd;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_data;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_count;
    logic [RD_W-1:0]       r_read_data;
    t_status               r_status;

    logic [POS_W-1:0]      w_pos_inc;
    logic [CNT_W-1:0]      w_ins_at;
    logic [CNT_W-1:0]      w_pos_cnt;
    logic [CNT_W-1:0]      w_idx_dn;
    logic [CNT_W-1:0]      w_idx_up;
    logic                  w_pos_m1;
    logic                  w_pos_ok;
    logic                  w_full;
    logic                  w_reject;
    logic                  w_more;
    t_status               w_status;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [ADDR_W-1:0]     w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    // Position checks against the current count.
    assign w_pos_inc = r_pos + POS_W'(1);
    assign w_ins_at  = CNT_W'(w_pos_inc);
    assign w_pos_cnt = CNT_W'(r_pos);
    assign w_idx_dn  = r_idx - CNT_W'(1);
    assign w_idx_up  = r_idx + CNT_W'(1);
    assign w_pos_m1  = (r_pos == '1);
    assign w_pos_ok  = !r_pos[POS_W-1] && (CMP_W'(r_pos) < CMP_W'(r_count));
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    // Rejection, status code and remaining shift work.
    always_comb begin
        w_reject = 1'b0;
        w_more   = 1'b0;
        unique case (r_cmd)
            CMD_INSERT: begin
                w_reject = w_full || !(w_pos_m1 || w_pos_ok);
                w_more   = (r_idx > w_ins_at);
            end
            CMD_DELETE: begin
                w_reject = !w_pos_ok;
                w_more   = ((CNT_W+1)'(r_idx) + (CNT_W+1)'(1)) < (CNT_W+1)'(r_count);
            end
            CMD_READ: begin
                w_reject = !w_pos_ok;
            end
            CMD_CLEAR: begin
                w_reject = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (r_cmd == CMD_INSERT && w_full) begin
            w_status = ST_FULL;
        end else if (w_reject) begin
            w_status = ST_BADPOS;
        end else begin
            w_status = ST_DONE;
        end
    end

    assign o_sts.cmd    = r_cmd;
    assign o_sts.reject = w_reject;
    assign o_sts.more   = w_more;

    // Memory ports: the shift reads one neighbor, then writes it one place over.
    assign w_we    = i_ctl.wr_shift || i_ctl.put;
    assign w_waddr = i_ctl.put ? w_ins_at[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign w_wdata = i_ctl.put ? r_data : w_rdata;
    assign w_re    = i_ctl.rd_shift || i_ctl.rd_pos;

    always_comb begin
        priority if (i_ctl.rd_pos) begin
            w_raddr = w_pos_cnt[ADDR_W-1:0];
        end else if (r_cmd == CMD_INSERT) begin
            w_raddr = w_idx_dn[ADDR_W-1:0];
        end else begin
            w_raddr = w_idx_up[ADDR_W-1:0];
        end
    end

    alid_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Item latch, shift index and result word.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_pos  <= i_position;
            r_data <= DATA_WIDTH'(i_entry_data);
        end
        if (i_ctl.init) begin
            r_idx <= (r_cmd == CMD_INSERT) ? r_count : w_pos_cnt;
        end else if (i_ctl.wr_shift) begin
            r_idx <= (r_cmd == CMD_INSERT) ? w_idx_dn : w_idx_up;
        end
        if (i_ctl.commit) begin
            r_status    <= w_status;
            r_read_data <= (r_cmd == CMD_READ && !w_reject) ? RD_W'(w_rdata) : '0;
        end
    end

    // Entry count, the only datapath state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.commit && !w_reject) begin
            unique case (r_cmd)
                CMD_INSERT: r_count <= w_idx_up - r_idx + r_count;
                CMD_DELETE: r_count <= r_count - CNT_W'(1);
                CMD_READ:   r_count <= r_count;
                CMD_CLEAR:  r_count <= '0;
            endcase
        end
    end

    assign o_read_data  = r_read_data;
    assign o_status     = r_status;
    assign o_item_count = COUNT_FW'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_is_full    = w_full;

endmodule

>>> rtl/alid_ctrl.sv
// Controller state machine of the array list.
`timescale 1ns / 1ps

module alid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output alid_pkg::t_dp_ctl o_ctl,
    input  alid_pkg::t_dp_sts i_sts
);

    import alid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_READ,
        S_COMMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_m_valid;
    logic    n_m_valid;
    logic    w_out_free;
    t_dp_ctl w_ctl;

    // The result word may be replaced once it is taken or empty.
    assign w_out_free = !r_m_valid || i_m_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                w_ctl.load = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                w_ctl.init = 1'b1;
                if (i_sts.reject) begin
                    n_state = S_COMMIT;
                end else begin
                    unique case (i_sts.cmd)
                        CMD_INSERT, CMD_DELETE: n_state = S_SHIFT_RD;
                        CMD_READ:               n_state = S_READ;
                        CMD_CLEAR:              n_state = S_COMMIT;
                    endcase
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.more) begin
                    w_ctl.rd_shift = 1'b1;
                    n_state        = S_SHIFT_WR;
                end else begin
                    w_ctl.put = (i_sts.cmd == CMD_INSERT);
                    n_state   = S_COMMIT;
                end
            end
            S_SHIFT_WR: begin
                w_ctl.wr_shift = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_READ: begin
                w_ctl.rd_pos = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    w_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        priority if (w_ctl.commit) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    // State and result-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // The input side stays closed while reset is held.
    assign o_s_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_valid = r_m_valid;
    assign o_ctl     = w_ctl;

endmodule
